@@ design/wmd_pkg.sv @@
// Shared definitions for the window motion detector: sizes, phase codes,
// register map, cell control struct and the truncating window-mean divide.
// No dependencies.
package wmd_pkg;

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int CLOG_W     = $clog2(WINDOW);
    localparam int SUM_BITS   = SAMPLE_BITS + CLOG_W;
    localparam int DEV_BITS   = SAMPLE_BITS + 1;
    localparam int THR_BITS   = 16;
    localparam int FILL_BITS  = $clog2(WINDOW + 2);
    localparam int MC_BITS    = $clog2(4 * WINDOW + 2);
    localparam int QC_BITS    = $clog2(WINDOW + 1);
    localparam int STAT_BITS  = 2;

    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((STAT_BITS + SAMPLE_BITS + 7) / 8) * 8;

    // APB map: one 32-bit register per word
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(64);

    // reciprocal for exact floor(x / WINDOW) over SUM_BITS-bit magnitudes
    localparam int DIV_SHIFT  = SUM_BITS + CLOG_W;
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    typedef enum logic [STAT_BITS-1:0] {
        ST_IDLE   = 2'd0,
        ST_MOTION = 2'd1,
        ST_SETTLE = 2'd2,
        ST_FINISH = 2'd3
    } phase_t;

    typedef struct packed {
        logic push;    // write sample at the token cell, advance token
        logic clear;   // zero every cell
        logic rehome;  // token back to the first cell
    } cell_ctl_t;

    typedef struct packed {
        logic gt;      // |deviation| above threshold
        logic lt;      // |deviation| below threshold
    } dev_cmp_t;

    // window sum / WINDOW, truncated toward zero
    function automatic logic signed [SAMPLE_BITS-1:0] div_window(
        input logic signed [SUM_BITS-1:0] sum
    );
        logic [SUM_BITS-1:0]    mag;
        logic [PROD_BITS-1:0]   prod;
        logic [SAMPLE_BITS:0]   quo;
        mag  = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
        prod = PROD_BITS'(mag) * PROD_BITS'(RECIP);
        quo  = prod[DIV_SHIFT +: SAMPLE_BITS + 1];
        return sum[SUM_BITS-1] ? SAMPLE_BITS'(-quo) : SAMPLE_BITS'(quo);
    endfunction

endpackage

@@ design/wmd_cell.sv @@
// One window slot: holds a sample and the write token, which it hands on
// to the next cell on each push. Depends on wmd_pkg.
module wmd_cell
    import wmd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctl_t                     ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          token_in,
    input  logic                          seed,
    output logic                          token_out,
    output logic        [SAMPLE_BITS-1:0] pick
);

    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic                          token_reg, token_next;
    logic                          holds;

    // seed stands for the home position held outside the row
    assign holds     = token_reg | seed;
    assign token_out = holds;
    assign pick      = holds ? value_reg : '0;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.clear)
        begin
            value_next = '0;
        end
        else if (ctl.push && holds)
        begin
            value_next = sample;
        end
    end

    always_comb
    begin
        token_next = token_reg;
        if (ctl.rehome)
        begin
            token_next = 1'b0;
        end
        else if (ctl.push)
        begin
            token_next = token_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            token_reg <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            token_reg <= token_next;
        end
    end

endmodule

@@ design/wmd_ctrl.sv @@
// Phase sequencer with fill, motion and quiet counters; drives the cell row.
// Depends on wmd_pkg.
module wmd_ctrl
    import wmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  dev_cmp_t  cmp,
    output cell_ctl_t ctl,
    output phase_t    phase
);

    phase_t               phase_reg, phase_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [MC_BITS-1:0]   motion_reg, motion_next;
    logic [QC_BITS-1:0]   quiet_reg, quiet_next;
    logic [QC_BITS-1:0]   quiet_upd;

    logic still, judged, hit, early, late, at_clear, past_clear, finish;

    assign still      = (phase_reg == ST_IDLE) || (phase_reg == ST_FINISH);
    assign judged     = fill_reg > FILL_BITS'(WINDOW);
    assign hit        = judged && cmp.gt;
    assign early      = motion_reg < MC_BITS'(2 * WINDOW);
    assign late       = motion_reg > MC_BITS'(4 * WINDOW);
    assign at_clear   = motion_reg == MC_BITS'(3 * WINDOW);
    assign past_clear = motion_reg > MC_BITS'(3 * WINDOW);
    assign finish     = !still && (phase_next == ST_FINISH);
    assign phase      = phase_reg;

    // quiet counter after judging, before the finish check
    always_comb
    begin
        quiet_upd = quiet_reg;
        if (late && cmp.lt && (quiet_reg < QC_BITS'(WINDOW)))
        begin
            quiet_upd = quiet_reg + QC_BITS'(1);
        end
        if (late && cmp.gt)
        begin
            quiet_upd = '0;
        end
    end

    always_comb
    begin
        phase_t ph;
        ph         = phase_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg) inside
                ST_IDLE, ST_FINISH:
                begin
                    if (hit)
                    begin
                        phase_next = ST_MOTION;
                    end
                end
                ST_MOTION, ST_SETTLE:
                begin
                    if (!early)
                    begin
                        if (late && cmp.lt)
                        begin
                            ph = ST_SETTLE;
                        end
                        if (late && cmp.gt)
                        begin
                            ph = ST_MOTION;
                        end
                        if ((ph == ST_SETTLE) && (quiet_upd >= QC_BITS'(WINDOW)))
                        begin
                            ph = ST_FINISH;
                        end
                        phase_next = ph;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        ctl         = '0;
        fill_next   = fill_reg;
        motion_next = motion_reg;
        quiet_next  = quiet_reg;
        if (accept)
        begin
            unique case (phase_reg) inside
                ST_IDLE, ST_FINISH:
                begin
                    ctl.push   = !hit;
                    ctl.rehome = hit;
                    if (!judged)
                    begin
                        fill_next = fill_reg + FILL_BITS'(1);
                    end
                end
                ST_MOTION, ST_SETTLE:
                begin
                    if (early)
                    begin
                        motion_next = motion_reg + MC_BITS'(1);
                    end
                    else
                    begin
                        ctl.clear = at_clear;
                        ctl.push  = past_clear;
                        if (finish)
                        begin
                            motion_next = '0;
                            quiet_next  = '0;
                        end
                        else
                        begin
                            quiet_next = quiet_upd;
                            if (!late)
                            begin
                                motion_next = motion_reg + MC_BITS'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    ctl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ST_IDLE;
            fill_reg   <= '0;
            motion_reg <= '0;
            quiet_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            motion_reg <= motion_next;
            quiet_reg  <= quiet_next;
        end
    end

    // settling is only reachable once the motion count has saturated
    a_settle_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ST_SETTLE) |-> (motion_reg == MC_BITS'(4 * WINDOW + 1)))
        else $error("settling before motion count saturated");

    // reaching a full quiet count always finishes, so it never rests at WINDOW
    a_quiet_below: assert property (@(posedge clk) disable iff (!rst_n)
        quiet_reg < QC_BITS'(WINDOW))
        else $error("quiet count left at window length");

    // entering motion from a still phase starts the motion count from zero
    a_motion_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && still && hit) |=> (phase_reg == ST_MOTION) && (motion_reg == '0))
        else $error("motion entered with stale count");

endmodule

@@ design/window_motion_detector.sv @@
// Top level of the window motion detector: stream ports, APB threshold
// register, running sum and mean, cell row and sequencer.
// Depends on wmd_pkg, wmd_cell and wmd_ctrl.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | s_tdata[15:0] sample
//  m_*       | out | m_tvalid/m_tready  | m_tdata[1:0] status, [17:2] mean
//  APB       | in  | psel/penable       | paddr word 0: threshold [15:0]
//
// One transaction in per cycle unless a result waits on m_tready; the
// result comes in the cycle after acceptance; sum and divide are combinational.
// Reset: window, sum, counters zero; phase idle; threshold 64.
// A result waiting on m_tready still lets a new sample in as it leaves.
module window_motion_detector
    import wmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [DATA_BITS-1:0]     pwdata,
    output logic [DATA_BITS-1:0]     prdata,
    output logic                     pready,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [15:0] sample
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata    // [1:0] status, [17:2] window_mean
);

    logic [THR_BITS-1:0]           thr_reg, thr_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic                          home_reg, home_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [DEV_BITS-1:0]    dev;
    logic [DEV_BITS-1:0]           dev_mag;
    dev_cmp_t                      cmp;
    cell_ctl_t                     ctl;
    phase_t                        phase;

    logic [WINDOW-1:0]             tok;
    logic [SAMPLE_BITS-1:0]        picks [WINDOW];
    logic [SAMPLE_BITS-1:0]        old_raw;

    assign pready   = 1'b1;
    assign prdata   = (paddr[ADDR_BITS-1] == REG_THRESHOLD) ? DATA_BITS'(thr_reg) : '0;
    assign thr_next = (psel && penable && pwrite && (paddr[ADDR_BITS-1] == REG_THRESHOLD))
                      ? pwdata[THR_BITS-1:0] : thr_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign m_tvalid = out_valid_reg;
    // state registers only move on acceptance, which frees the slot first
    assign m_tdata  = OUT_DATA_BITS'({mean_reg, phase});

    assign out_valid_next = accept || (out_valid_reg && !m_tready);

    // deviation against the mean before this sample enters
    assign dev     = DEV_BITS'(sample) - DEV_BITS'(mean_reg);
    assign dev_mag = dev[DEV_BITS-1] ? DEV_BITS'(-dev) : DEV_BITS'(dev);
    assign cmp.gt  = dev_mag > DEV_BITS'(thr_reg);
    assign cmp.lt  = dev_mag < DEV_BITS'(thr_reg);

    wmd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmp    (cmp),
        .ctl    (ctl),
        .phase  (phase)
    );

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
        logic seed;
        if (i == 0)
        begin : g_home
            assign seed = home_reg;
        end
        else
        begin : g_rest
            assign seed = 1'b0;
        end
        wmd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sample    (sample),
            .token_in  (tok[PREV]),
            .seed      (seed),
            .token_out (tok[i]),
            .pick      (picks[i])
        );
    end

    // only the token cell drives a non-zero pick
    always_comb
    begin
        old_raw = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            old_raw = old_raw | picks[i];
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.push)
        begin
            sum_next = sum_reg + SUM_BITS'(sample) - SUM_BITS'($signed(old_raw));
        end
    end

    assign mean_next = div_window(sum_next);

    always_comb
    begin
        home_next = home_reg;
        if (ctl.rehome)
        begin
            home_next = 1'b1;
        end
        else if (ctl.push)
        begin
            home_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            sum_reg       <= '0;
            mean_reg      <= '0;
            home_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            sum_reg       <= sum_next;
            mean_reg      <= mean_next;
            home_reg      <= home_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // exactly one cell owns the write position
    a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(tok))
        else $error("write token lost or duplicated");

    // a window clear leaves sum and mean at zero
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.clear) |=> (sum_reg == '0) && (mean_reg == '0))
        else $error("window clear left residue");

endmodule

@@ tb/tb_window_motion_detector.sv @@
// Self-checking testbench for window_motion_detector: stream stimulus with random idling,
// APB threshold writes, an in-bench predictor of the window mean and phase sequence.
// Depends on wmd_pkg and the window_motion_detector RTL.
module tb_window_motion_detector
    import wmd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam logic [ADDR_BITS-1:0] THR_ADDR = ADDR_BITS'(4 * REG_THRESHOLD);

    typedef struct packed {
        phase_t                        status;
        logic signed [SAMPLE_BITS-1:0] mean;
    } detector_out_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]     paddr    = '0;
    logic [DATA_BITS-1:0]     pwdata   = '0;
    logic [DATA_BITS-1:0]     prdata;
    logic                     pready;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;   // [15:0] sample
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // [1:0] status, [17:2] window_mean

    // predictor state
    int     win_buf [WINDOW];
    int     wr_ptr     = 0;
    int     run_sum    = 0;
    int     fill_cnt   = 0;
    int     motion_cnt = 0;
    int     quiet_cnt  = 0;
    int     thr_val    = int'(THRESHOLD_RESET);
    phase_t det_phase  = ST_IDLE;

    detector_out_t expected_results [$];
    int  fault_count  = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  hold_request = 0;
    int  hold_left    = 0;
    bit  offering     = 1'b0;

    window_motion_detector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int window_mean_now();
        return run_sum / WINDOW;   // int division truncates toward zero
    endfunction

    function automatic void push_window(input int smp);
        run_sum         = run_sum + smp - win_buf[wr_ptr];
        win_buf[wr_ptr] = smp;
        wr_ptr          = (wr_ptr + 1) % WINDOW;
    endfunction

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advances the predicted detector by one sample; deviation uses the mean before the push.
    function automatic detector_out_t predict_sample(input int smp);
        detector_out_t res;
        int            dev;
        dev = abs_int(smp - window_mean_now());
        if (det_phase == ST_IDLE || det_phase == ST_FINISH)
        begin
            if (fill_cnt > WINDOW && dev > thr_val)
            begin
                det_phase = ST_MOTION;
                wr_ptr    = 0;
            end
            else
            begin
                if (fill_cnt <= WINDOW)
                    fill_cnt++;
                push_window(smp);
            end
        end
        else if (motion_cnt < 2 * WINDOW)
        begin
            motion_cnt++;
        end
        else
        begin
            if (motion_cnt == 3 * WINDOW)
            begin
                foreach (win_buf[i])
                    win_buf[i] = 0;
                run_sum = 0;
            end
            if (motion_cnt > 3 * WINDOW)
                push_window(smp);
            if (motion_cnt > 4 * WINDOW)
            begin
                if (dev < thr_val)
                begin
                    det_phase = ST_SETTLE;
                    if (quiet_cnt < WINDOW)
                        quiet_cnt++;
                end
                if (dev > thr_val)
                begin
                    det_phase = ST_MOTION;
                    quiet_cnt = 0;
                end
            end
            if (det_phase == ST_SETTLE && quiet_cnt >= WINDOW)
            begin
                det_phase  = ST_FINISH;
                motion_cnt = 0;
                quiet_cnt  = 0;
            end
            else if (motion_cnt <= 4 * WINDOW)
            begin
                motion_cnt++;
            end
        end
        res.status = det_phase;
        res.mean   = SAMPLE_BITS'(window_mean_now());
        return res;
    endfunction

    // Mostly well-formed traffic: quiet samples once judging is on, with rare jumps,
    // samples exactly at the threshold, and more frequent full-range noise while nothing is judged.
    function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
        int m;
        int v;
        int k;
        int r;
        bit judged;
        m = window_mean_now();
        r = int'($urandom_range(0, 99));
        if (det_phase == ST_IDLE || det_phase == ST_FINISH)
            judged = (fill_cnt > WINDOW);
        else
            judged = (motion_cnt > 4 * WINDOW);
        if (!judged)
        begin
            if (r < 15)
                v = int'($urandom_range(0, 65535)) - 32768;
            else
                v = m + int'($urandom_range(0, 6000)) - 3000;
        end
        else if (r < 2)
        begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end
        else if (r < 5)
        begin
            k = thr_val + 1 + int'($urandom_range(0, 1000));
            v = ($urandom_range(0, 1) && (m - k >= -32768)) ? m - k : m + k;
        end
        else if (r < 13)
        begin
            v = $urandom_range(0, 1) ? m + thr_val : m - thr_val;
        end
        else
        begin
            k = (thr_val > 4000) ? 4000 : thr_val - 1;
            if (k < 0)
                k = 0;
            v = m + int'($urandom_range(0, 2 * k)) - k;
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        s_tdata  <= IN_DATA_BITS'({smp});
        s_tvalid <= 1'b1;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_sample(int'(smp)));
        if (int'($urandom_range(0, 99)) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic await_results();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_check_threshold();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[THR_BITS-1:0] !== THR_BITS'(thr_val))
        begin
            $display("%0t threshold readback: expected %0d, actual %0d",
                     $time, thr_val, prdata[THR_BITS-1:0]);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_threshold(input int thr);
        await_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        // upper bits are junk; only the low 16 should stick
        pwdata  <= {16'($urandom_range(0, 65535)), thr[THR_BITS-1:0]};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_val = thr & 32'hFFFF;
        @(posedge clk);
        apb_check_threshold();
    endtask

    // Fill with field extremes under the reset threshold, then a jump into motion.
    task automatic test_fill_and_detect();
        logic signed [SAMPLE_BITS-1:0] fill_vals [8];
        fill_vals = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001,
                      16'sh0001, 16'sh4000, -16'sh4000, 16'sh5555};
        apb_check_threshold();
        foreach (fill_vals[i])
            offer_sample(fill_vals[i]);
        repeat (WINDOW + 1 - 8)
            offer_sample(16'sh0064);
        offer_sample(SAMPLE_BITS'(window_mean_now() + 10));
        offer_sample(SAMPLE_BITS'(window_mean_now() - 64));
        offer_sample(-16'sh8000);
        offer_sample(16'sh7FFF);
        offer_sample(16'sh0000);
        offer_sample(-16'sh0001);
        await_results();
    endtask

    task automatic test_motion_cycles(input int thr, input int count);
        set_threshold(thr);
        repeat (count)
            offer_sample(next_sample());
    endtask

    // Zero threshold: any nonzero deviation is motion; full scale: nothing ever is.
    task automatic test_threshold_extremes();
        set_threshold(0);
        repeat (60)
            offer_sample(next_sample());
        set_threshold(32'hFFFF);
        repeat (60)
            offer_sample(next_sample());
    endtask

    // Long output stall while the sender keeps offering, then a full drain.
    task automatic test_output_stall();
        await_results();
        hold_request = 300;
        repeat (50)
            offer_sample(next_sample());
        await_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        detector_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result transaction: actual %h", $time, m_tdata);
                fault_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[STAT_BITS-1:0] !== want.status)
                begin
                    $display("%0t status: expected %0d, actual %0d",
                             $time, want.status, m_tdata[STAT_BITS-1:0]);
                    fault_count++;
                end
                if (m_tdata[STAT_BITS +: SAMPLE_BITS] !== want.mean)
                begin
                    $display("%0t window_mean: expected %0d, actual %0d", $time, want.mean,
                             $signed(m_tdata[STAT_BITS +: SAMPLE_BITS]));
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("window_motion_detector: mismatch");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_idle_pct = 7;
        rx_idle_pct = 45;
        test_fill_and_detect();
        test_motion_cycles(100, 100);
        test_motion_cycles(int'($urandom_range(1, 2000)), 100);

        tx_idle_pct = 45;
        rx_idle_pct = 7;
        test_threshold_extremes();
        test_motion_cycles(300, 80);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_motion_cycles(int'(THRESHOLD_RESET), 60);
        test_output_stall();

        await_results();
        repeat (4) @(posedge clk);
        if (fault_count == 0)
            $display("window_motion_detector: match");
        else
            $display("window_motion_detector: mismatch");
        $finish;
    end

endmodule
